>>> hw/rtl/oah_pkg.sv
`default_nettype none
package oah_pkg;

  // Table geometry and field widths
  localparam int TABLE_DEPTH = 512;
  localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
  localparam int KEY_BITS    = 16;
  localparam int COUNT_BITS  = 10;
  localparam int DIVD_BITS   = KEY_BITS;
  localparam int CNT_BITS    = $clog2(DIVD_BITS);

  // Configuration registers
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 10;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_USED_SIZE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PROBE_MODE = 2'd1;
  localparam logic [COUNT_BITS-1:0] USED_SIZE_RESET = 10'd311;

  // Operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // Double-hash step is (key mod STEP_DIVISOR) + 1
  localparam logic [COUNT_BITS-1:0] STEP_DIVISOR = 10'd10;

  // key * STEP_RECIP >> STEP_SHIFT equals key / 10 for every key below 2**18
  localparam logic [KEY_BITS-1:0] STEP_RECIP = 16'd52429;
  localparam int                  STEP_SHIFT = 19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MODSTEP,
    ST_MODKEY,
    ST_PROBE,
    ST_READ
  } state_t;

  // One table slot as stored in memory
  typedef struct packed {
    logic                  full;
    logic [COUNT_BITS-1:0] probes;
    logic [KEY_BITS-1:0]   key;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // Request to the shared remainder unit
  typedef struct packed {
    logic                  start;
    logic [DIVD_BITS-1:0]  dividend;
    logic [COUNT_BITS-1:0] divisor;
  } mod_req_t;

  // Clamp the configured size into 1 .. TABLE_DEPTH
  function automatic logic [COUNT_BITS-1:0] eff_size(input logic [COUNT_BITS-1:0] used);
    logic [COUNT_BITS-1:0] n;
    n = used;
    if (n == '0) n = COUNT_BITS'(1);
    if (n > COUNT_BITS'(TABLE_DEPTH)) n = COUNT_BITS'(TABLE_DEPTH);
    return n;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/oah_ram.sv
`default_nettype none
module oah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/oah_mod_unit.sv
`default_nettype none
module oah_mod_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  oah_pkg::mod_req_t                 req,
  output logic                              done,
  output logic [oah_pkg::COUNT_BITS-1:0]    rem
);
  import oah_pkg::*;

  logic                   running;
  logic [CNT_BITS-1:0]    cnt;
  logic [DIVD_BITS-1:0]   dvd;
  logic [COUNT_BITS-1:0]  dsr;
  logic [COUNT_BITS:0]    trial;

  // Shift in the next dividend bit and subtract the divisor if it fits
  assign trial = {rem, dvd[DIVD_BITS-1]};

  // Restoring remainder, one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        dvd     <= req.dividend;
        dsr     <= req.divisor;
      end else if (running) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= COUNT_BITS'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[COUNT_BITS-1:0];
        end
        dvd <= {dvd[DIVD_BITS-2:0], 1'b0};
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(DIVD_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dsr))
    else $error("remainder not below divisor");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_no_done_while_running: assert property (@(posedge clk) disable iff (rst)
    running |-> !done)
    else $error("done raised while still iterating");

endmodule
`default_nettype wire

>>> hw/rtl/open_address_hash_insert.sv
`default_nettype none
// Open-addressing hash table with linear or double-hash probing.
//
// Command channel: drive func, key_value and read_slot with start high; the
// transaction is taken at the rising edge where start is high and busy is low.
// busy stays high until the result is presented. Each command returns exactly
// one result, shown for one cycle with result_valid high; the receiver cannot
// stall it, and a new command may be taken in the same cycle the result shows.
// Configuration: cfg_valid/cfg_ready write channel, index 0 used_size,
// index 1 probe_mode; cfg_ready is always high. Write only while idle.
//
// Commands are served by the single remainder unit and the one-read-per-cycle
// slot memory; one command is in flight at a time:
//   insert, either mode: two remainder passes, then one slot read per probe
//   read: one slot read, clear: one slot per cycle, unused func: answered
//   from idle, busy never rises.
// Reset runs a clearing pass through every slot of the slot memory with busy
// high; configuration writes are still taken meanwhile.
module open_address_hash_insert (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           func,
  input  logic [oah_pkg::KEY_BITS-1:0]         key_value,
  input  logic [oah_pkg::SLOT_BITS-1:0]        read_slot,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [oah_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [oah_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                 result_valid,
  output logic [oah_pkg::SLOT_BITS-1:0]        slot_index,
  output logic [oah_pkg::COUNT_BITS-1:0]       probe_total,
  output logic [oah_pkg::KEY_BITS-1:0]         entry_key,
  output logic                                 entry_valid,
  output logic                                 no_slot
);
  import oah_pkg::*;

  state_t                 state, state_next;
  logic [COUNT_BITS-1:0]  used_size;
  logic                   probe_mode;
  logic [COUNT_BITS-1:0]  n_eff, n_eff_next;
  logic [KEY_BITS-1:0]    key_r, key_r_next;
  logic [SLOT_BITS-1:0]   step, step_next;
  logic [SLOT_BITS-1:0]   pos, pos_next;
  logic [COUNT_BITS-1:0]  count, count_next;
  logic [SLOT_BITS-1:0]   clr, clr_next;
  logic                   clear_reply, clear_reply_next;

  logic                   res_valid_next;
  logic [SLOT_BITS-1:0]   slot_index_next;
  logic [COUNT_BITS-1:0]  probe_total_next;
  logic [KEY_BITS-1:0]    entry_key_next;
  logic                   entry_valid_next;
  logic                   no_slot_next;

  mod_req_t               mreq;
  logic                   mdone;
  logic [COUNT_BITS-1:0]  mrem;

  logic                   ram_we;
  logic [SLOT_BITS-1:0]   ram_waddr, ram_raddr;
  entry_t                 ram_wdata, ram_rdata;

  logic [COUNT_BITS-1:0]  pos_sum;
  logic [SLOT_BITS-1:0]   pos_adv;
  logic                   accept;

  logic [2*KEY_BITS-1:0]  key_prod;
  logic [KEY_BITS-1:0]    key_quot;
  logic [KEY_BITS-1:0]    key_rem10;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Key mod 10 for the double-hash step, by reciprocal multiplication
  assign key_prod  = {{KEY_BITS{1'b0}}, key_value} * {{KEY_BITS{1'b0}}, STEP_RECIP};
  assign key_quot  = KEY_BITS'(key_prod >> STEP_SHIFT);
  assign key_rem10 = key_value - KEY_BITS'(key_quot * KEY_BITS'(STEP_DIVISOR));

  // Next probe position, wrapped into the table
  assign pos_sum = {1'b0, pos} + {1'b0, step};
  assign pos_adv = (pos_sum >= n_eff) ? SLOT_BITS'(pos_sum - n_eff)
                                      : pos_sum[SLOT_BITS-1:0];

  oah_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mdone),
    .rem  (mrem)
  );

  oah_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used_size  <= USED_SIZE_RESET;
      probe_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_USED_SIZE:  used_size  <= COUNT_BITS'(cfg_data);
        CFG_PROBE_MODE: probe_mode <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr          <= '0;
      clear_reply  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      clr          <= clr_next;
      clear_reply  <= clear_reply_next;
      result_valid <= res_valid_next;
    end
    n_eff       <= n_eff_next;
    key_r       <= key_r_next;
    step        <= step_next;
    pos         <= pos_next;
    count       <= count_next;
    slot_index  <= slot_index_next;
    probe_total <= probe_total_next;
    entry_key   <= entry_key_next;
    entry_valid <= entry_valid_next;
    no_slot     <= no_slot_next;
  end

  always_comb begin
    state_next       = state;
    n_eff_next       = n_eff;
    key_r_next       = key_r;
    step_next        = step;
    pos_next         = pos;
    count_next       = count;
    clr_next         = clr;
    clear_reply_next = clear_reply;
    res_valid_next   = 1'b0;
    slot_index_next  = slot_index;
    probe_total_next = probe_total;
    entry_key_next   = entry_key;
    entry_valid_next = entry_valid;
    no_slot_next     = no_slot;
    mreq             = '0;
    ram_we           = 1'b0;
    ram_waddr        = pos;
    ram_wdata        = '0;
    ram_raddr        = pos;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          n_eff_next = eff_size(used_size);
          key_r_next = key_value;
          case (func)
            FUNC_INSERT: begin
              // Reduce the step by the table size first
              mreq.start   = 1'b1;
              mreq.divisor = eff_size(used_size);
              state_next   = ST_MODSTEP;
              if (probe_mode) begin
                mreq.dividend = key_rem10 + DIVD_BITS'(1);
              end else begin
                mreq.dividend = DIVD_BITS'(1);
              end
            end
            FUNC_CLEAR: begin
              clr_next         = '0;
              clear_reply_next = 1'b1;
              state_next       = ST_CLEAR;
            end
            FUNC_READ: begin
              ram_raddr  = read_slot;
              pos_next   = read_slot;
              state_next = ST_READ;
            end
            default: begin
              res_valid_next   = 1'b1;
              slot_index_next  = '0;
              probe_total_next = '0;
              entry_key_next   = '0;
              entry_valid_next = 1'b0;
              no_slot_next     = 1'b0;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        // Sweep one slot per cycle, marking it empty
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = '0;
        clr_next  = clr + SLOT_BITS'(1);
        if (clr == SLOT_BITS'(TABLE_DEPTH - 1)) begin
          state_next       = ST_IDLE;
          clear_reply_next = 1'b0;
          if (clear_reply) begin
            res_valid_next   = 1'b1;
            slot_index_next  = '0;
            probe_total_next = '0;
            entry_key_next   = '0;
            entry_valid_next = 1'b0;
            no_slot_next     = 1'b0;
          end
        end
      end

      ST_MODSTEP: begin
        if (mdone) begin
          step_next     = mrem[SLOT_BITS-1:0];
          mreq.start    = 1'b1;
          mreq.dividend = key_r;
          mreq.divisor  = n_eff;
          state_next    = ST_MODKEY;
        end
      end

      ST_MODKEY: begin
        // Home slot found: fetch it
        if (mdone) begin
          pos_next   = mrem[SLOT_BITS-1:0];
          ram_raddr  = mrem[SLOT_BITS-1:0];
          count_next = COUNT_BITS'(1);
          state_next = ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (!ram_rdata.full) begin
          ram_we           = 1'b1;
          ram_waddr        = pos;
          ram_wdata.full   = 1'b1;
          ram_wdata.probes = count;
          ram_wdata.key    = key_r;
          res_valid_next   = 1'b1;
          slot_index_next  = pos;
          probe_total_next = count;
          entry_key_next   = '0;
          entry_valid_next = 1'b0;
          no_slot_next     = 1'b0;
          state_next       = ST_IDLE;
        end else if (count == n_eff) begin
          res_valid_next   = 1'b1;
          slot_index_next  = '0;
          probe_total_next = n_eff;
          entry_key_next   = '0;
          entry_valid_next = 1'b0;
          no_slot_next     = 1'b1;
          state_next       = ST_IDLE;
        end else begin
          // Advance and fetch the next slot
          pos_next   = pos_adv;
          ram_raddr  = pos_adv;
          count_next = count + COUNT_BITS'(1);
        end
      end

      ST_READ: begin
        res_valid_next  = 1'b1;
        slot_index_next = pos;
        no_slot_next    = 1'b0;
        if (ram_rdata.full) begin
          probe_total_next = ram_rdata.probes;
          entry_key_next   = ram_rdata.key;
          entry_valid_next = 1'b1;
        end else begin
          probe_total_next = '0;
          entry_key_next   = '0;
          entry_valid_next = 1'b0;
        end
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> ((pos < n_eff) && (count <= n_eff) && (count != '0)))
    else $error("probe position or count out of range");

  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || result_valid))
    else $error("accepted command neither busy nor answered");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(entry_valid && no_slot))
    else $error("result both valid entry and no slot");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while still busy");

endmodule
`default_nettype wire
